// File: rtl/mxt_pkg.sv
// Shared types and constants for the max-xor binary trie block.
// Used by max_xor_binary_trie_top, mxt_checker and the bench; depends on nothing else.
package mxt_pkg;

  localparam int KEY_BITS   = 18;
  localparam int NODE_COUNT = 4096;
  localparam int COUNT_BITS = 16;

  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int POOL_BITS  = NODE_BITS + 1;
  localparam int LEVEL_BITS = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NEED_BITS  = $clog2(KEY_BITS + 1);

  // item codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_POOL_FULL = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [17:0] key;
  } req_t;

  typedef struct packed {
    logic [17:0] best_xor;
    status_t     status;
  } rsp_t;

  // one trie node as stored in the node memory
  typedef struct packed {
    logic [NODE_BITS-1:0]  zero_child;
    logic [NODE_BITS-1:0]  one_child;
    logic [COUNT_BITS-1:0] count;
  } node_t;

endpackage

// File: rtl/max_xor_binary_trie_top.sv
// Throughput: one item at a time; a new item is taken once the result is in the output
// register, which holds it until transferred; a held result delays the next one.
// Reset: clears sequencer, output valid, root links and pool pointer; the node memory is
// not cleared, each node is written when allocated, before it is ever read.
// Top level of the max-xor binary trie; node memory, sequencer and output register.
// Depends on mxt_pkg.
module max_xor_binary_trie_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mxt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mxt_pkg::rsp_t rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_INS_WALK, S_INS_CHECK, S_INS_ROOT, S_INS_UPDATE, S_INS_FRESH,
    S_REM_WALK, S_REM_ROOT, S_REM_UPDATE, S_QRY_ROOT0, S_QRY_ROOT1, S_QRY_STEP,
    S_QRY_OTHER, S_QRY_SAME, S_DONE
  } state_t;

  localparam logic [mxt_pkg::LEVEL_BITS-1:0] TOP_LEVEL =
    mxt_pkg::LEVEL_BITS'(mxt_pkg::KEY_BITS - 1);
  localparam logic [mxt_pkg::LEVEL_BITS-1:0] LEVEL_ONE = mxt_pkg::LEVEL_BITS'(1);
  localparam logic [mxt_pkg::NODE_BITS-1:0]  NO_NODE = '0;

  state_t                          state;
  logic [1:0]                      mode_r;
  logic [17:0]                     key_r;
  logic [mxt_pkg::LEVEL_BITS-1:0]  level;
  logic [mxt_pkg::NODE_BITS-1:0]   node;
  logic [mxt_pkg::NODE_BITS-1:0]   cur_z;
  logic [mxt_pkg::NODE_BITS-1:0]   cur_o;
  logic [mxt_pkg::NODE_BITS-1:0]   root_z;
  logic [mxt_pkg::NODE_BITS-1:0]   root_o;
  logic [mxt_pkg::POOL_BITS-1:0]   nf;
  logic [mxt_pkg::NEED_BITS-1:0]   needed;
  logic                            ovf;
  logic                            has0;
  logic [17:0]                     acc;
  mxt_pkg::status_t                res_status;

  // node memory
  mxt_pkg::node_t                  mem [mxt_pkg::NODE_COUNT];
  mxt_pkg::node_t                  rd_data;
  mxt_pkg::node_t                  wr_data;
  logic                            rd_en;
  logic                            wr_en;
  logic [mxt_pkg::NODE_BITS-1:0]   rd_addr;
  logic [mxt_pkg::NODE_BITS-1:0]   wr_addr;

  // path helpers
  logic                            bit_now;
  logic                            bit_nxt;
  logic [mxt_pkg::NODE_BITS-1:0]   root_sel;
  logic [mxt_pkg::NODE_BITS-1:0]   rd_next;
  logic [mxt_pkg::NODE_BITS-1:0]   q_other;
  logic [mxt_pkg::NODE_BITS-1:0]   q_same;
  logic [mxt_pkg::NODE_BITS-1:0]   nf_node;
  logic [mxt_pkg::POOL_BITS:0]     pool_sum;
  logic                            rd_cnt_zero;
  logic                            rd_cnt_max;
  logic                            req_take;

  assign req_stall   = (state != S_IDLE);
  assign req_take    = req_valid && !req_stall;
  assign bit_now     = key_r[level];
  assign bit_nxt     = key_r[level - LEVEL_ONE];
  assign root_sel    = bit_now ? root_o : root_z;
  assign rd_next     = bit_nxt ? rd_data.one_child : rd_data.zero_child;
  assign q_other     = bit_now ? cur_z : cur_o;
  assign q_same      = bit_now ? cur_o : cur_z;
  assign nf_node     = nf[mxt_pkg::NODE_BITS-1:0];
  assign pool_sum    = {1'b0, nf} + (mxt_pkg::POOL_BITS + 1)'(needed);
  assign rd_cnt_zero = (rd_data.count == '0);
  assign rd_cnt_max  = &rd_data.count;

  // memory array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // memory access control per sequencer step
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = root_sel;
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = rd_data;
    unique case (state)
      S_START: begin
        if (mode_r == mxt_pkg::MODE_QUERY) begin
          rd_en   = 1'b1;
          rd_addr = root_z;
        end else begin
          rd_en   = (root_sel != NO_NODE);
        end
      end
      S_INS_ROOT, S_REM_ROOT: begin
        rd_en = (root_sel != NO_NODE);
      end
      S_INS_WALK, S_REM_WALK: begin
        rd_en   = (level != '0) && (rd_next != NO_NODE);
        rd_addr = rd_next;
      end
      S_INS_UPDATE: begin
        wr_en         = 1'b1;
        wr_data.count = rd_data.count + mxt_pkg::COUNT_BITS'(1);
        if (level != '0) begin
          if (rd_next == NO_NODE) begin
            // path ends here, link the first new node
            if (bit_nxt) begin
              wr_data.one_child = nf_node;
            end else begin
              wr_data.zero_child = nf_node;
            end
          end else begin
            rd_en   = 1'b1;
            rd_addr = rd_next;
          end
        end
      end
      S_INS_FRESH: begin
        wr_en              = 1'b1;
        wr_data.zero_child = NO_NODE;
        wr_data.one_child  = NO_NODE;
        wr_data.count      = mxt_pkg::COUNT_BITS'(1);
        if (level != '0) begin
          if (bit_nxt) begin
            wr_data.one_child = nf_node;
          end else begin
            wr_data.zero_child = nf_node;
          end
        end
      end
      S_REM_UPDATE: begin
        wr_en         = 1'b1;
        wr_data.count = rd_data.count - mxt_pkg::COUNT_BITS'(1);
        rd_en         = (level != '0);
        rd_addr       = rd_next;
      end
      S_QRY_ROOT0: begin
        rd_en   = 1'b1;
        rd_addr = root_o;
      end
      S_QRY_STEP: begin
        rd_en   = (q_other != NO_NODE) || (q_same != NO_NODE);
        rd_addr = (q_other != NO_NODE) ? q_other : q_same;
      end
      S_QRY_OTHER: begin
        rd_en   = rd_cnt_zero && (q_same != NO_NODE);
        rd_addr = q_same;
      end
      default: begin
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      root_z    <= NO_NODE;
      root_o    <= NO_NODE;
      nf        <= mxt_pkg::POOL_BITS'(1);
    end else begin
      // result leaves unless a new one takes its place below
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            mode_r     <= req.mode;
            key_r      <= req.key;
            level      <= TOP_LEVEL;
            ovf        <= 1'b0;
            acc        <= '0;
            res_status <= mxt_pkg::ST_OK;
            state      <= S_START;
          end
        end
        S_START: begin
          unique case (mode_r)
            mxt_pkg::MODE_INSERT: begin
              if (root_sel == NO_NODE) begin
                needed <= mxt_pkg::NEED_BITS'(mxt_pkg::KEY_BITS);
                state  <= S_INS_CHECK;
              end else begin
                state <= S_INS_WALK;
              end
            end
            mxt_pkg::MODE_REMOVE: begin
              if (root_sel == NO_NODE) begin
                res_status <= mxt_pkg::ST_ABSENT;
                state      <= S_DONE;
              end else begin
                state <= S_REM_WALK;
              end
            end
            mxt_pkg::MODE_QUERY: begin
              state <= S_QRY_ROOT0;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        // insert, first pass: find where the path ends and check counts
        S_INS_WALK: begin
          if (rd_cnt_max) begin
            ovf <= 1'b1;
          end
          if (level == '0) begin
            needed <= '0;
            state  <= S_INS_CHECK;
          end else if (rd_next == NO_NODE) begin
            needed <= mxt_pkg::NEED_BITS'(level);
            state  <= S_INS_CHECK;
          end else begin
            level <= level - LEVEL_ONE;
          end
        end
        S_INS_CHECK: begin
          level <= TOP_LEVEL;
          if (pool_sum > (mxt_pkg::POOL_BITS + 1)'(mxt_pkg::NODE_COUNT)) begin
            res_status <= mxt_pkg::ST_POOL_FULL;
            state      <= S_DONE;
          end else if (ovf) begin
            res_status <= mxt_pkg::ST_OVERFLOW;
            state      <= S_DONE;
          end else begin
            state <= S_INS_ROOT;
          end
        end
        // insert, second pass: bump counts and allocate the missing tail
        S_INS_ROOT: begin
          if (root_sel == NO_NODE) begin
            if (bit_now) begin
              root_o <= nf_node;
            end else begin
              root_z <= nf_node;
            end
            node  <= nf_node;
            nf    <= nf + mxt_pkg::POOL_BITS'(1);
            state <= S_INS_FRESH;
          end else begin
            node  <= root_sel;
            state <= S_INS_UPDATE;
          end
        end
        S_INS_UPDATE: begin
          if (level == '0) begin
            state <= S_DONE;
          end else begin
            level <= level - LEVEL_ONE;
            if (rd_next == NO_NODE) begin
              node  <= nf_node;
              nf    <= nf + mxt_pkg::POOL_BITS'(1);
              state <= S_INS_FRESH;
            end else begin
              node <= rd_next;
            end
          end
        end
        S_INS_FRESH: begin
          if (level == '0) begin
            state <= S_DONE;
          end else begin
            level <= level - LEVEL_ONE;
            node  <= nf_node;
            nf    <= nf + mxt_pkg::POOL_BITS'(1);
          end
        end
        // remove, first pass: every node on the path must exist with a count
        S_REM_WALK: begin
          if (rd_cnt_zero) begin
            res_status <= mxt_pkg::ST_ABSENT;
            state      <= S_DONE;
          end else if (level == '0) begin
            level <= TOP_LEVEL;
            state <= S_REM_ROOT;
          end else if (rd_next == NO_NODE) begin
            res_status <= mxt_pkg::ST_ABSENT;
            state      <= S_DONE;
          end else begin
            level <= level - LEVEL_ONE;
          end
        end
        S_REM_ROOT: begin
          node  <= root_sel;
          state <= S_REM_UPDATE;
        end
        S_REM_UPDATE: begin
          if (level == '0) begin
            state <= S_DONE;
          end else begin
            level <= level - LEVEL_ONE;
            node  <= rd_next;
          end
        end
        // query: root children counts, then greedy walk
        S_QRY_ROOT0: begin
          has0  <= (root_z != NO_NODE) && !rd_cnt_zero;
          state <= S_QRY_ROOT1;
        end
        S_QRY_ROOT1: begin
          cur_z <= root_z;
          cur_o <= root_o;
          if (!has0 && !((root_o != NO_NODE) && !rd_cnt_zero)) begin
            res_status <= mxt_pkg::ST_EMPTY;
            state      <= S_DONE;
          end else begin
            state <= S_QRY_STEP;
          end
        end
        S_QRY_STEP: begin
          priority if (q_other != NO_NODE) begin
            state <= S_QRY_OTHER;
          end else if (q_same != NO_NODE) begin
            state <= S_QRY_SAME;
          end else begin
            state <= S_DONE;
          end
        end
        S_QRY_OTHER: begin
          if (!rd_cnt_zero) begin
            acc[level] <= 1'b1;
            cur_z      <= rd_data.zero_child;
            cur_o      <= rd_data.one_child;
            if (level == '0) begin
              state <= S_DONE;
            end else begin
              level <= level - LEVEL_ONE;
              state <= S_QRY_STEP;
            end
          end else if (q_same == NO_NODE) begin
            state <= S_DONE;
          end else begin
            state <= S_QRY_SAME;
          end
        end
        S_QRY_SAME: begin
          cur_z <= rd_data.zero_child;
          cur_o <= rd_data.one_child;
          if (level == '0) begin
            state <= S_DONE;
          end else begin
            level <= level - LEVEL_ONE;
            state <= S_QRY_STEP;
          end
        end
        // hand the result to the output register once it is free
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid    <= 1'b1;
            rsp.best_xor <= acc;
            rsp.status   <= res_status;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/mxt_checker.sv
// Port-level checks for max_xor_binary_trie_top, attached by the bind below.
// Depends on mxt_pkg.
module mxt_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input mxt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input mxt_pkg::rsp_t rsp
);

  // one item at a time: a transfer in closes the input at once
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input open right after a transfer");

  // an item with a status other than ok reports no xor value
  a_xor_only_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != mxt_pkg::ST_OK) |-> rsp.best_xor == '0)
    else $error("nonzero best_xor with error status");

  // a result never appears straight out of idle with no result held
  a_no_result_from_idle: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid && !req_stall |=> !rsp_valid)
    else $error("result without an item in work");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // after reset the block is empty and open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("block not idle after reset");

endmodule

bind max_xor_binary_trie_top mxt_checker u_mxt_checker (.*);

// File: bench/max_xor_binary_trie_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for max_xor_binary_trie_top: a directed table, random insert, remove
// and query traffic and pool exhaustion, checked against a bench trie or pinned expectations.
// Depends on mxt_pkg and max_xor_binary_trie_top.
module max_xor_binary_trie_top_tb;

  // mode code the block ignores
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1050;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int POOL_GUARD   = 1500;
  localparam int TIMEOUT_NS   = 20_000_000;

  typedef struct {
    logic [1:0]                   mode;
    logic [mxt_pkg::KEY_BITS-1:0] key;
    int                           reps;
    bit                           pinned;
    logic [mxt_pkg::KEY_BITS-1:0] best;
    mxt_pkg::status_t             status;
  } step_t;

  localparam int NUM_STEPS = 25;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_stall;
  mxt_pkg::req_t  req;
  logic           rsp_valid;
  logic           rsp_stall;
  mxt_pkg::rsp_t  rsp;

  int send_idle_pct = 10;
  int recv_idle_pct = 70;
  int hold_requests = 0;
  int failures      = 0;

  mxt_pkg::rsp_t                expected_rsp [$];
  logic [mxt_pkg::KEY_BITS-1:0] live_keys [$];

  // bench copy of the trie
  logic [mxt_pkg::NODE_BITS-1:0]  trie_zero [mxt_pkg::NODE_COUNT];
  logic [mxt_pkg::NODE_BITS-1:0]  trie_one  [mxt_pkg::NODE_COUNT];
  logic [mxt_pkg::COUNT_BITS-1:0] trie_cnt  [mxt_pkg::NODE_COUNT];
  int unsigned                    trie_next;

  // directed items; pinned rows carry an expectation that is obvious by hand
  step_t script [NUM_STEPS] = '{
    '{mxt_pkg::MODE_QUERY,  18'h00000, 1, 1'b1, 18'h00000, mxt_pkg::ST_EMPTY},
    '{mxt_pkg::MODE_REMOVE, 18'h3ffff, 1, 1'b1, 18'h00000, mxt_pkg::ST_ABSENT},
    '{MODE_SPARE,           18'h2aaaa, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_INSERT, 18'h00000, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h3ffff, 1, 1'b1, 18'h3ffff, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h00000, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_INSERT, 18'h3ffff, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h00000, 1, 1'b1, 18'h3ffff, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h15555, 1, 1'b0, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h15555, 1, 1'b1, 18'h00000, mxt_pkg::ST_ABSENT},
    '{mxt_pkg::MODE_INSERT, 18'h3fffe, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h3ffff, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h3ffff, 1, 1'b1, 18'h00000, mxt_pkg::ST_ABSENT},
    '{mxt_pkg::MODE_QUERY,  18'h3ffff, 1, 1'b0, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_INSERT, 18'h20000, 2, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h20000, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h1ffff, 1, 1'b0, 18'h00000, mxt_pkg::ST_OK},
    '{MODE_SPARE,           18'h3ffff, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_INSERT, 18'h2aaaa, 1, 1'b0, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h00000, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h20000, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h3fffe, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_REMOVE, 18'h2aaaa, 1, 1'b1, 18'h00000, mxt_pkg::ST_OK},
    '{mxt_pkg::MODE_QUERY,  18'h12345, 1, 1'b1, 18'h00000, mxt_pkg::ST_EMPTY},
    '{mxt_pkg::MODE_INSERT, 18'h15555, 1, 1'b0, 18'h00000, mxt_pkg::ST_OK}
  };

  max_xor_binary_trie_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a node holds keys if it exists and its count is nonzero
  function automatic bit node_live(input logic [mxt_pkg::NODE_BITS-1:0] c);
    return (c != '0) && (trie_cnt[c] != '0);
  endfunction

  // applies one item to the bench trie and returns the result it should produce
  function automatic mxt_pkg::rsp_t trie_apply(input mxt_pkg::req_t r);
    mxt_pkg::rsp_t                 o;
    int                            lvl;
    int unsigned                   need;
    logic [mxt_pkg::NODE_BITS-1:0] nd;
    logic [mxt_pkg::NODE_BITS-1:0] c;
    logic [mxt_pkg::NODE_BITS-1:0] other;
    bit                            ovf;
    bit                            walking;
    o.best_xor = '0;
    o.status   = mxt_pkg::ST_OK;
    nd         = '0;
    walking    = 1'b1;
    case (r.mode)
      mxt_pkg::MODE_INSERT: begin
        // dry walk: nodes still to allocate and any count already at its ceiling
        need = 0;
        ovf  = 1'b0;
        for (lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0 && walking; lvl--) begin
          c = r.key[lvl] ? trie_one[nd] : trie_zero[nd];
          if (c == '0) begin
            need    = lvl + 1;
            walking = 1'b0;
          end else begin
            if (trie_cnt[c] == '1) ovf = 1'b1;
            nd = c;
          end
        end
        if (trie_next + need > mxt_pkg::NODE_COUNT) begin
          o.status = mxt_pkg::ST_POOL_FULL;
        end else if (ovf) begin
          o.status = mxt_pkg::ST_OVERFLOW;
        end else begin
          nd = '0;
          for (lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            c = r.key[lvl] ? trie_one[nd] : trie_zero[nd];
            if (c == '0) begin
              c = mxt_pkg::NODE_BITS'(trie_next);
              trie_next++;
              trie_zero[c] = '0;
              trie_one[c]  = '0;
              trie_cnt[c]  = '0;
              if (r.key[lvl]) trie_one[nd] = c;
              else trie_zero[nd] = c;
            end
            trie_cnt[c] = trie_cnt[c] + 1'b1;
            nd = c;
          end
        end
      end
      mxt_pkg::MODE_REMOVE: begin
        for (lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0 && walking; lvl--) begin
          c = r.key[lvl] ? trie_one[nd] : trie_zero[nd];
          if (!node_live(c)) begin
            o.status = mxt_pkg::ST_ABSENT;
            walking  = 1'b0;
          end else begin
            nd = c;
          end
        end
        if (o.status == mxt_pkg::ST_OK) begin
          nd = '0;
          for (lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            c = r.key[lvl] ? trie_one[nd] : trie_zero[nd];
            trie_cnt[c] = trie_cnt[c] - 1'b1;
            nd = c;
          end
        end
      end
      mxt_pkg::MODE_QUERY: begin
        if (!node_live(trie_zero[0]) && !node_live(trie_one[0])) begin
          o.status = mxt_pkg::ST_EMPTY;
        end else begin
          // greedy walk toward the opposite bit
          for (lvl = mxt_pkg::KEY_BITS - 1; lvl >= 0 && walking; lvl--) begin
            other = r.key[lvl] ? trie_zero[nd] : trie_one[nd];
            if (node_live(other)) begin
              o.best_xor[lvl] = 1'b1;
              nd = other;
            end else begin
              nd = r.key[lvl] ? trie_one[nd] : trie_zero[nd];
              if (nd == '0) walking = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // random item, mostly built around keys already stored
  function automatic mxt_pkg::req_t pick_req(input int fresh_pct);
    mxt_pkg::req_t                r;
    logic [mxt_pkg::KEY_BITS-1:0] base;
    int unsigned                  roll;
    roll = $urandom_range(99);
    if (live_keys.size() != 0) base = live_keys[$urandom_range(live_keys.size() - 1)];
    else base = mxt_pkg::KEY_BITS'($urandom);
    r.key = mxt_pkg::KEY_BITS'($urandom);
    if (roll < 3) begin
      r.mode = MODE_SPARE;
    end else if (roll < 45) begin
      r.mode = mxt_pkg::MODE_INSERT;
      roll = $urandom_range(99);
      if (roll >= fresh_pct)
        r.key = (roll < 60) ? base ^ mxt_pkg::KEY_BITS'($urandom_range(63)) : base;
    end else if (roll < 70) begin
      r.mode = mxt_pkg::MODE_REMOVE;
      if ($urandom_range(3) != 0) r.key = base;
      else if ($urandom_range(1) != 0) r.key = base ^ mxt_pkg::KEY_BITS'($urandom_range(15, 1));
    end else begin
      r.mode = mxt_pkg::MODE_QUERY;
      roll = $urandom_range(3);
      if (roll == 0) r.key = base;
      else if (roll == 1) r.key = ~base;
    end
    return r;
  endfunction

  // predicts one item, then offers it until the block takes the transfer
  task automatic offer(input mxt_pkg::req_t item, input bit pinned,
                       input mxt_pkg::rsp_t pinned_rsp, output mxt_pkg::status_t got);
    mxt_pkg::rsp_t want;
    int            i;
    int            hit;
    want = trie_apply(item);
    got  = want.status;
    if (want.status == mxt_pkg::ST_OK && item.mode == mxt_pkg::MODE_INSERT)
      live_keys = {live_keys, item.key};
    if (want.status == mxt_pkg::ST_OK && item.mode == mxt_pkg::MODE_REMOVE) begin
      hit = -1;
      for (i = live_keys.size() - 1; i >= 0 && hit < 0; i--)
        if (live_keys[i] == item.key) hit = i;
      if (hit >= 0) live_keys.delete(hit);
    end
    if (pinned) want = pinned_rsp;
    // sender gaps
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp = {expected_rsp, want};
    @(negedge clk);
  endtask

  // result side stall, with an occasional long hold-off
  initial begin : rsp_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : rsp_check
    mxt_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        $error("unexpected result: best_xor %h status %0d", rsp.best_xor, rsp.status);
        failures++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.best_xor !== want.best_xor) begin
          $error("best_xor mismatch: expected %h, actual %h", want.best_xor, rsp.best_xor);
          failures++;
        end
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
          failures++;
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    mxt_pkg::req_t    r;
    mxt_pkg::rsp_t    fixed;
    mxt_pkg::status_t st;
    int               i;
    int               seg;
    int               pool_full_hits;
    int               guard;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    for (i = 0; i < mxt_pkg::NODE_COUNT; i++) begin
      trie_zero[i] = '0;
      trie_one[i]  = '0;
      trie_cnt[i]  = '0;
    end
    trie_next = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (i = 0; i < NUM_STEPS; i++) begin
      repeat (script[i].reps) begin
        r.mode         = script[i].mode;
        r.key          = script[i].key;
        fixed.best_xor = script[i].best;
        fixed.status   = script[i].status;
        offer(r, script[i].pinned, fixed, st);
      end
    end

    // random traffic under three idling profiles
    for (seg = 0; seg < 3; seg++) begin
      send_idle_pct = (seg == 0) ? 10 : (seg == 1) ? 70 : 0;
      recv_idle_pct = (seg == 0) ? 70 : (seg == 1) ? 10 : 0;
      if (seg == 2) begin
        // back up the block behind a long result hold-off, then drain it fully
        hold_requests++;
        repeat (12) offer(pick_req(10), 1'b0, fixed, st);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge clk);
      end
      repeat (RANDOM_ITEMS / 3) offer(pick_req(10), 1'b0, fixed, st);
    end

    // use up the node pool, with small-need inserts to hit its exact end
    pool_full_hits = 0;
    guard          = 0;
    while ((pool_full_hits < 12 || trie_next < mxt_pkg::NODE_COUNT) && guard < POOL_GUARD)
    begin
      guard++;
      if ($urandom_range(3) == 0) begin
        r = pick_req(0);
      end else begin
        r.mode = mxt_pkg::MODE_INSERT;
        if ($urandom_range(1) != 0 || live_keys.size() == 0)
          r.key = mxt_pkg::KEY_BITS'($urandom);
        else r.key = live_keys[$urandom_range(live_keys.size() - 1)] ^
                     mxt_pkg::KEY_BITS'($urandom_range(7, 1));
      end
      offer(r, 1'b0, fixed, st);
      if (st == mxt_pkg::ST_POOL_FULL) pool_full_hits++;
    end

    // a little more mixed traffic on the full trie
    send_idle_pct = 10;
    recv_idle_pct = 70;
    repeat (40) offer(pick_req(30), 1'b0, fixed, st);

    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("max_xor_binary_trie_top_tb: PASS");
    end else begin
      $display("max_xor_binary_trie_top_tb: FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("max_xor_binary_trie_top_tb: FAIL");
    $finish;
  end

endmodule
